// File: rtl/core/dsp_pkg.sv
package dsp_pkg;

  // field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned PosW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonAccW = 7;
  localparam int unsigned DayAccW = 10;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;

  // saturation points of the digit accumulators
  localparam logic [YearW-1:0]   YearSat  = 14'd10000;
  localparam logic [MonAccW-1:0] MonthSat = 7'd100;
  localparam logic [DayAccW-1:0] DaySat   = 10'd1000;
  localparam logic [YearW-1:0]   YearMax  = 14'd9999;

  // character codes
  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChNine = 8'h39;
  localparam logic [CharW-1:0] ChDot  = 8'h2E;
  localparam logic [CharW-1:0] ChDash = 8'h2D;

  // positions within the calendar form
  localparam logic [PosW-1:0] PosSep1  = 4'd4;
  localparam logic [PosW-1:0] PosMon0  = 4'd5;
  localparam logic [PosW-1:0] PosMon1  = 4'd6;
  localparam logic [PosW-1:0] PosSep2  = 4'd7;
  localparam logic [PosW-1:0] PosDay0  = 4'd8;
  localparam logic [PosW-1:0] PosDay1  = 4'd9;
  localparam logic [PosW-1:0] CalLen   = 4'd10;
  localparam logic [PosW-1:0] PosMax   = 4'd15;

  // result form codes
  localparam logic FormOrdinal  = 1'b0;
  localparam logic FormCalendar = 1'b1;

  // scan state, plus the last four year digits for the leap test
  typedef struct packed {
    logic [PosW-1:0]       pos;
    logic                  ord_ok;
    logic                  cal_ok;
    logic                  dot_seen;
    logic                  dig_after_dot;
    logic [YearW-1:0]      year;
    logic [MonAccW-1:0]    month;
    logic [DayAccW-1:0]    day;
    logic [3:0][3:0]       ydig;
  } scan_st_t;

  localparam scan_st_t ScanReset = '{
    pos: '0, ord_ok: 1'b1, cal_ok: 1'b1, dot_seen: 1'b0, dig_after_dot: 1'b0,
    year: '0, month: '0, day: '0, ydig: '0
  };

  typedef struct packed {
    logic              valid_res;
    logic              form_kind;
    logic [YearW-1:0]  year;
    logic [MonW-1:0]   month;
    logic [DayW-1:0]   day;
  } date_res_t;

  // acc * 10 + d, clamped at sat
  function automatic logic [YearW-1:0] acc_digit(input logic [YearW-1:0] acc,
                                                 input logic [3:0] d,
                                                 input logic [YearW-1:0] sat);
    logic [YearW+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{YearW{1'b0}}, d};
    return (v >= {4'd0, sat}) ? sat : v[YearW-1:0];
  endfunction

  // days in month 1..12
  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // days of the year before month 1..12
  function automatic logic [DoyW-1:0] month_start(input logic [MonW-1:0] m,
                                                  input logic leap);
    logic [DoyW-1:0] s;
    case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && m >= 4'd3) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

// File: rtl/core/dsp_scan.sv
module dsp_scan import dsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             last_char_i,
  output scan_st_t         st_o
);

  scan_st_t         st_q, st_d;
  logic             digit;
  logic [3:0]       dval;
  logic [CharW-1:0] dsub;
  logic             year_en;
  logic             day_en;

  // digit decode
  assign digit = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign dsub  = char_code_i - ChZero;
  assign dval  = digit ? dsub[3:0] : 4'd0;

  assign year_en = digit && !st_q.dot_seen && (st_q.ord_ok || st_q.pos < PosSep1);
  // ordinal day digits and calendar day digits never occur on the same beat
  assign day_en  = digit && ((st_q.ord_ok && st_q.dot_seen) ||
                   (st_q.cal_ok && (st_q.pos == PosDay0 || st_q.pos == PosDay1)));

  // per-character state update
  always_comb begin
    st_d = st_q;

    if (year_en) begin
      st_d.year = acc_digit(st_q.year, dval, YearSat);
      st_d.ydig = {st_q.ydig[2:0], dval};
    end

    if (day_en) begin
      st_d.day = DayAccW'(acc_digit({{(YearW-DayAccW){1'b0}}, st_q.day}, dval,
                                   {{(YearW-DayAccW){1'b0}}, DaySat}));
    end

    // ordinal form tracking
    if (st_q.ord_ok) begin
      if (digit) begin
        if (st_q.dot_seen) begin
          st_d.dig_after_dot = 1'b1;
        end
      end else if (char_code_i == ChDot && !st_q.dot_seen && st_q.pos != '0) begin
        st_d.dot_seen = 1'b1;
      end else begin
        st_d.ord_ok = 1'b0;
      end
    end

    // calendar form tracking
    if (st_q.cal_ok) begin
      if (st_q.pos == PosSep1 || st_q.pos == PosSep2) begin
        if (char_code_i != ChDash) begin
          st_d.cal_ok = 1'b0;
        end
      end else if (st_q.pos > PosDay1 || !digit) begin
        st_d.cal_ok = 1'b0;
      end else if (st_q.pos == PosMon0 || st_q.pos == PosMon1) begin
        st_d.month = MonAccW'(acc_digit({{(YearW-MonAccW){1'b0}}, st_q.month}, dval,
                                       {{(YearW-MonAccW){1'b0}}, MonthSat}));
      end
    end

    if (st_q.pos != PosMax) begin
      st_d.pos = st_q.pos + 4'd1;
    end
  end

  // state register, back to reset after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ScanReset;
    end else if (step_i) begin
      st_q <= last_char_i ? ScanReset : st_d;
    end
  end

  assign st_o = st_d;

endmodule

// File: rtl/core/dsp_check.sv
module dsp_check import dsp_pkg::*; (
  input  scan_st_t  st_i,
  output date_res_t res_o
);

  logic [4:0]         lo2, hi2;
  logic               hund_zero;
  logic               leap;
  logic               yr_ok;
  logic               ord_branch;
  logic               cal_branch;
  logic [DayAccW-1:0] lim;
  logic [MonW-1:0]    conv_mon;
  logic [DoyW-1:0]    conv_start;
  logic [DayAccW-1:0] conv_day;
  logic [MonW-1:0]    cal_mon;

  // leap year from the last four decimal digits
  assign lo2       = {st_i.ydig[1], 1'b0} + {1'b0, st_i.ydig[0]};
  assign hi2       = {st_i.ydig[3], 1'b0} + {1'b0, st_i.ydig[2]};
  assign hund_zero = (st_i.ydig[1] == 4'd0) && (st_i.ydig[0] == 4'd0);
  assign leap      = ((lo2[1:0] == 2'd0) && !hund_zero) ||
                     (hund_zero && (hi2[1:0] == 2'd0));

  assign yr_ok = (st_i.year != '0) && (st_i.year <= YearMax);
  assign lim   = leap ? 10'd366 : 10'd365;

  // day of year to month and day
  always_comb begin
    conv_mon   = 4'd1;
    conv_start = '0;
    for (int k = 2; k <= 12; k++) begin
      if (st_i.day > {1'b0, month_start(MonW'(k), leap)}) begin
        conv_mon   = MonW'(k);
        conv_start = month_start(MonW'(k), leap);
      end
    end
  end
  assign conv_day = st_i.day - {1'b0, conv_start};

  assign cal_mon    = st_i.month[MonW-1:0];
  assign ord_branch = st_i.ord_ok && st_i.dot_seen && st_i.dig_after_dot && yr_ok;
  assign cal_branch = st_i.cal_ok && (st_i.pos == CalLen) && yr_ok &&
                      (st_i.month >= 7'd1) && (st_i.month <= 7'd12) &&
                      (st_i.day != '0) &&
                      (st_i.day <= {5'd0, month_days(cal_mon, leap)});

  // final result selection
  always_comb begin
    res_o = '0;
    if (ord_branch) begin
      if (st_i.day != '0 && st_i.day <= lim) begin
        res_o.valid_res = 1'b1;
        res_o.form_kind = FormOrdinal;
        res_o.year      = st_i.year;
        res_o.month     = conv_mon;
        res_o.day       = conv_day[DayW-1:0];
      end
    end else if (cal_branch) begin
      res_o.valid_res = 1'b1;
      res_o.form_kind = FormCalendar;
      res_o.year      = st_i.year;
      res_o.month     = cal_mon;
      res_o.day       = st_i.day[DayW-1:0];
    end
  end

endmodule

// File: rtl/core/date_string_parse_validate.sv
// channel | signals                                       | beat
// --------+-----------------------------------------------+-------------------------------
// in      | in_valid_i / in_ready_o, char_code_i, last_char_i | one character of the string
// out     | out_valid_o / out_ready_i, valid_res_o, form_kind_o,
//         | year_out_o, month_out_o, day_out_o             | one result per string
//
// one character per cycle: an input register, then the scan update and the
// end-of-string date check in one pass into the result register.
// a result is registered from the final character held in the input register.
// reset clears the scan state and both valid flags; no clearing pass.
// only a final character waiting behind an untaken result stalls the input.
module date_string_parse_validate import dsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_code_i,
  input  logic             last_char_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             valid_res_o,
  output logic             form_kind_o,
  output logic [YearW-1:0] year_out_o,
  output logic [MonW-1:0]  month_out_o,
  output logic [DayW-1:0]  day_out_o
);

  logic             vld_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             out_vld_q;
  date_res_t        res_q;
  date_res_t        res_d;
  scan_st_t         st;
  logic             advance;

  // the registered character moves on unless its result has nowhere to go
  assign advance    = vld_q && (!last_q || !out_vld_q || out_ready_i);
  assign in_ready_o = !vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  dsp_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .char_code_i (char_q),
    .last_char_i (last_q),
    .st_o        (st)
  );

  dsp_check u_check (
    .st_i  (st),
    .res_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign valid_res_o = res_q.valid_res;
  assign form_kind_o = res_q.form_kind;
  assign year_out_o  = res_q.year;
  assign month_out_o = res_q.month;
  assign day_out_o   = res_q.day;

endmodule

// File: bench/tb_date_string_parse_validate.sv
// running model of the date scanner plus the dates it still owes
class date_checker;
  logic [dsp_pkg::PosW-1:0] pos;
  bit                       ord_ok;
  bit                       cal_ok;
  bit                       dot_seen;
  bit                       day_digits;
  int unsigned              year_acc;
  int unsigned              mon_acc;
  int unsigned              day_acc;
  dsp_pkg::date_res_t       expected_dates[$];
  int unsigned              n_errors;

  function new();
    n_errors = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    pos        = '0;
    ord_ok     = 1'b1;
    cal_ok     = 1'b1;
    dot_seen   = 1'b0;
    day_digits = 1'b0;
    year_acc   = 0;
    mon_acc    = 0;
    day_acc    = 0;
  endfunction

  // shift in one decimal digit, clamp at the saturation point
  function int unsigned sat_push(int unsigned acc, int unsigned dv, int unsigned sat);
    int unsigned v;
    v = acc * 10 + dv;
    return (v >= sat) ? sat : v;
  endfunction

  function bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function int unsigned days_of(int unsigned y, int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // one accepted character beat; a final character queues the date it implies
  function void scan_char(logic [7:0] c, logic fin);
    bit                 is_dig;
    int unsigned        dv;
    int unsigned        p;
    int unsigned        yr;
    int unsigned        lim;
    int unsigned        doy;
    int unsigned        mo;
    dsp_pkg::date_res_t r;
    p      = pos;
    is_dig = (c >= dsp_pkg::ChZero) && (c <= dsp_pkg::ChNine);
    dv     = is_dig ? (c - dsp_pkg::ChZero) : 0;

    // year: leading digit run of the ordinal form or the first four places
    if (is_dig && !dot_seen && (ord_ok || p < dsp_pkg::PosSep1)) begin
      year_acc = sat_push(year_acc, dv, dsp_pkg::YearSat);
    end

    // ordinal form
    if (ord_ok) begin
      if (is_dig) begin
        if (dot_seen) begin
          day_digits = 1'b1;
          day_acc    = sat_push(day_acc, dv, dsp_pkg::DaySat);
        end
      end else if (c == dsp_pkg::ChDot && !dot_seen && p > 0) begin
        dot_seen = 1'b1;
      end else begin
        ord_ok = 1'b0;
      end
    end

    // calendar form
    if (cal_ok) begin
      if (p == dsp_pkg::PosSep1 || p == dsp_pkg::PosSep2) begin
        if (c != dsp_pkg::ChDash) begin
          cal_ok = 1'b0;
        end
      end else if (p > dsp_pkg::PosDay1 || !is_dig) begin
        cal_ok = 1'b0;
      end else if (p == dsp_pkg::PosMon0 || p == dsp_pkg::PosMon1) begin
        mon_acc = sat_push(mon_acc, dv, dsp_pkg::MonthSat);
      end else if (p == dsp_pkg::PosDay0 || p == dsp_pkg::PosDay1) begin
        day_acc = sat_push(day_acc, dv, dsp_pkg::DaySat);
      end
    end

    if (pos != dsp_pkg::PosMax) begin
      pos = pos + 1'b1;
    end

    if (!fin) begin
      return;
    end

    // end of string: decide the form and fill the date
    r  = '0;
    yr = year_acc;
    if (ord_ok && dot_seen && day_digits && yr >= 1 && yr <= dsp_pkg::YearMax) begin
      lim = leap_year(yr) ? 366 : 365;
      doy = day_acc;
      if (doy >= 1 && doy <= lim) begin
        mo = 1;
        while (mo < 12 && doy > days_of(yr, mo)) begin
          doy = doy - days_of(yr, mo);
          mo++;
        end
        r.valid_res = 1'b1;
        r.form_kind = dsp_pkg::FormOrdinal;
        r.year      = yr[dsp_pkg::YearW-1:0];
        r.month     = mo[dsp_pkg::MonW-1:0];
        r.day       = doy[dsp_pkg::DayW-1:0];
      end
    end else if (cal_ok && pos == dsp_pkg::CalLen && yr >= 1 && yr <= dsp_pkg::YearMax &&
                 mon_acc >= 1 && mon_acc <= 12 &&
                 day_acc >= 1 && day_acc <= days_of(yr, mon_acc)) begin
      r.valid_res = 1'b1;
      r.form_kind = dsp_pkg::FormCalendar;
      r.year      = yr[dsp_pkg::YearW-1:0];
      r.month     = mon_acc[dsp_pkg::MonW-1:0];
      r.day       = day_acc[dsp_pkg::DayW-1:0];
    end
    expected_dates.push_back(r);
    clear_scan();
  endfunction

  task flag(string what);
    n_errors++;
    $display("mismatch: %s", what);
  endtask

  // one result beat against the oldest owed date
  task check_result(logic v, logic f, logic [dsp_pkg::YearW-1:0] y,
                    logic [dsp_pkg::MonW-1:0] m, logic [dsp_pkg::DayW-1:0] d);
    dsp_pkg::date_res_t w;
    if (expected_dates.size() == 0) begin
      flag("result beat with no string pending");
      return;
    end
    w = expected_dates.pop_front();
    if (v !== w.valid_res) begin
      flag($sformatf("valid_res got %b want %b (year %0d)", v, w.valid_res, w.year));
    end
    if (f !== w.form_kind) begin
      flag($sformatf("form_kind got %b want %b (year %0d)", f, w.form_kind, w.year));
    end
    if (y !== w.year) begin
      flag($sformatf("year_out got %0d want %0d", y, w.year));
    end
    if (m !== w.month) begin
      flag($sformatf("month_out got %0d want %0d (year %0d)", m, w.month, w.year));
    end
    if (d !== w.day) begin
      flag($sformatf("day_out got %0d want %0d (year %0d)", d, w.day, w.year));
    end
  endtask
endclass

module tb_date_string_parse_validate import dsp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PhaseItems  = 600;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [CharW-1:0] char_code_i = '0;
  logic             last_char_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             valid_res_o;
  logic             form_kind_o;
  logic [YearW-1:0] year_out_o;
  logic [MonW-1:0]  month_out_o;
  logic [DayW-1:0]  day_out_o;

  date_checker      chk;
  logic [CharW-1:0] text_buf[$];
  int unsigned      phase = 0;
  int unsigned      snd_idle = 34;
  int unsigned      n_sent = 0;
  int unsigned      hold_left = 0;
  bit               hold_done = 1'b0;
  int unsigned      stall_cycles = 0;

  string directed_text [17] = '{
    "1.1", "0001.001", "2000.366", "1900.366", "00012.060", "99999.1", "2024.0",
    "2024-02-29", "2023-02-29", "0000-01-01", "9999-12-31", "2024-13-01",
    ".5", "5.", "1.2.3", "today", "2024-1-01"
  };

  date_string_parse_validate u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .valid_res_o (valid_res_o),
    .form_kind_o (form_kind_o),
    .year_out_o  (year_out_o),
    .month_out_o (month_out_o),
    .day_out_o   (day_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // one character beat, with a random gap in front of it
  task automatic send_beat(input logic [CharW-1:0] c, input logic fin);
    if ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_beat(text_buf[i], i == text_buf.size() - 1);
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_buf.push_back(s[i]);
    end
  endtask

  task automatic add_zeros(input int unsigned n);
    repeat (n) text_buf.push_back(ChZero);
  endtask

  // years weighted toward zero, the top and the century leap rules
  function automatic int unsigned pick_year();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 9999;
      2:       return 100 * $urandom_range(1, 99);
      3:       return 4 * $urandom_range(1, 2499);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  function automatic int unsigned pick_doy();
    case ($urandom_range(9))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(364, 367);
      2:       return $urandom_range(1000, 99999);
      default: return $urandom_range(1, 366);
    endcase
  endfunction

  // mostly well-formed dates with random content, the rest noise
  task automatic build_random_text();
    int unsigned kind;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned n;
    int unsigned k;
    text_buf.delete();
    kind = $urandom_range(99);
    if (kind < 34) begin
      y = pick_year();
      m = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12);
      d = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 31);
      add_text($sformatf("%04d-%02d-%02d", y, m, d));
    end else if (kind < 66) begin
      y = ($urandom_range(11) == 0) ? $urandom_range(10000, 999999) : pick_year();
      d = pick_doy();
      add_zeros(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      add_text($sformatf("%0d.", y));
      add_zeros(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      add_text($sformatf("%0d", d));
    end else if (kind < 88) begin
      n = $urandom_range(1, 20);
      repeat (n) begin
        case ($urandom_range(19))
          0, 1, 2: text_buf.push_back(ChDash);
          3, 4, 5: text_buf.push_back(ChDot);
          6, 7:    text_buf.push_back(CharW'($urandom_range(255)));
          default: text_buf.push_back(ChZero + CharW'($urandom_range(9)));
        endcase
      end
    end else begin
      n = $urandom_range(1, 20);
      repeat (n) text_buf.push_back(CharW'($urandom_range(255)));
    end

    // break some well-formed strings by one character
    if (kind < 66 && $urandom_range(7) == 0) begin
      k = $urandom_range(text_buf.size() - 1);
      case ($urandom_range(2))
        0: text_buf[k] = CharW'($urandom_range(255));
        1: if (text_buf.size() > 1) text_buf.delete(k);
        default: text_buf.insert(k, ChZero + CharW'($urandom_range(9)));
      endcase
    end
  endtask

  // stimulus and end of run
  initial begin
    chk = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings, then the odd bytes and an overlong run
    foreach (directed_text[i]) begin
      text_buf.delete();
      add_text(directed_text[i]);
      send_text();
    end
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b1);
    text_buf.delete();
    add_text("12345678901234567");
    send_text();

    // random strings under three idle profiles
    for (int p = 0; p < 3; p++) begin
      phase    <= p;
      snd_idle = (p == 0) ? 34 : (p == 1) ? 46 : 0;
      while (n_sent < (p + 1) * PhaseItems) begin
        build_random_text();
        send_text();
      end
    end
    in_valid_i <= 1'b0;

    while (chk.expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (chk.n_errors == 0 && chk.expected_dates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side ready, with one long hold at the start of the last phase
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= ((phase == 0) ? 46 : (phase == 1) ? 34 : 0);
    end
  end

  // monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      chk.scan_char(char_code_i, last_char_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      chk.check_result(valid_res_o, form_kind_o, year_out_o, month_out_o, day_out_o);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/core/dsp_pkg.sv
rtl/core/dsp_scan.sv
rtl/core/dsp_check.sv
rtl/core/date_string_parse_validate.sv
bench/tb_date_string_parse_validate.sv
